FILE: hw/rtl/stok_pkg.sv
package stok_pkg;

    localparam int unsigned MAX_TOKEN   = 8192;
    localparam int unsigned LEN_W       = $clog2(MAX_TOKEN);
    localparam int unsigned LIM_MAX     = MAX_TOKEN - 1;
    localparam int unsigned CFG_W       = 13;
    localparam int unsigned RES_MAX     = 4;
    localparam int unsigned RES_IDX_W   = $clog2(RES_MAX);
    localparam int unsigned RES_CNT_W   = $clog2(RES_MAX + 1);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd8191;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_WORD    = 3'd4,
        MODE_DISCARD = 3'd5
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       quoted;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]      count;
        result_t [RES_MAX-1:0]     res;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hw/rtl/stok_front.sv
module stok_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,     // text_byte
    input  logic                      cfg_wr_en,
    input  logic [stok_pkg::CFG_W-1:0] cfg_wr_data, // token_limit
    input  stok_pkg::q_status_t       q_stat,
    output logic                      push,
    output stok_pkg::group_t          push_grp
);
    import stok_pkg::*;

    scan_mode_t        mode_reg;
    scan_mode_t        mode_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [CFG_W-1:0]  limit_reg;

    logic [7:0]        c;
    logic              is_zero;
    logic              is_ws;
    logic              is_single;
    logic              slash_pre;
    logic [LEN_W-1:0]  lim;
    logic              lim_one;
    scan_mode_t        m_eff;
    logic [LEN_W-1:0]  l_eff;
    logic [LEN_W-1:0]  cut_len;
    logic [LEN_W:0]    inc;
    logic              cut;
    logic              accept;

    function automatic result_t make_res(kind_t k, logic [7:0] ch, logic q);
        result_t r;
        r.kind   = k;
        r.ch     = ch;
        r.quoted = q;
        return r;
    endfunction

    assign c         = s_tdata;
    assign is_zero   = (c == CH_NUL);
    assign is_ws     = !is_zero && (c <= CH_SPACE);
    assign is_single = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
                       (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COLON) ||
                       (c == CH_EQUALS);

    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = LEN_W'(1);
        end
        else if (32'(limit_reg) > LIM_MAX)
        begin
            lim = LEN_W'(LIM_MAX);
        end
        else
        begin
            lim = LEN_W'(limit_reg);
        end
    end

    assign lim_one   = (lim == LEN_W'(1));
    assign slash_pre = (mode_reg == MODE_SLASH) && (c != CH_SLASH);

    // a lone slash becomes the first character of a word, or a whole token when the limit is one
    always_comb
    begin
        if (slash_pre)
        begin
            m_eff = lim_one ? MODE_SKIP : MODE_WORD;
            l_eff = lim_one ? '0 : LEN_W'(1);
        end
        else
        begin
            l_eff = len_reg;
            case (mode_reg)
                MODE_SLASH:   m_eff = MODE_SLASH;
                MODE_COMMENT: m_eff = MODE_COMMENT;
                MODE_QUOTED:  m_eff = MODE_QUOTED;
                MODE_WORD:    m_eff = MODE_WORD;
                MODE_DISCARD: m_eff = MODE_DISCARD;
                default:      m_eff = MODE_SKIP;
            endcase
        end
    end

    assign cut_len = (m_eff == MODE_SKIP) ? '0 : l_eff;
    assign inc     = {1'b0, cut_len} + {{LEN_W{1'b0}}, 1'b1};
    assign cut     = (inc >= {1'b0, lim});

    always_comb
    begin
        mode_next = m_eff;
        len_next  = l_eff;
        case (m_eff)
            MODE_SLASH:
            begin
                mode_next = MODE_COMMENT;
            end
            MODE_SKIP:
            begin
                if (is_zero)
                begin
                    len_next = '0;
                end
                else if (is_ws)
                begin
                    mode_next = MODE_SKIP;
                end
                else if (c == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_QUOTED;
                    len_next  = '0;
                end
                else if (is_single)
                begin
                    len_next = '0;
                end
                else
                begin
                    mode_next = cut ? MODE_SKIP : MODE_WORD;
                    len_next  = cut ? '0 : inc[LEN_W-1:0];
                end
            end
            MODE_WORD:
            begin
                if (is_zero || is_ws || is_single)
                begin
                    mode_next = MODE_SKIP;
                    len_next  = '0;
                end
                else
                begin
                    mode_next = cut ? MODE_SKIP : MODE_WORD;
                    len_next  = cut ? '0 : inc[LEN_W-1:0];
                end
            end
            MODE_COMMENT:
            begin
                if (is_zero)
                begin
                    mode_next = MODE_SKIP;
                    len_next  = '0;
                end
                else if (c == CH_NL)
                begin
                    mode_next = MODE_SKIP;
                end
            end
            MODE_QUOTED:
            begin
                if (is_zero || (c == CH_QUOTE))
                begin
                    mode_next = MODE_SKIP;
                    len_next  = '0;
                end
                else
                begin
                    mode_next = cut ? MODE_DISCARD : MODE_QUOTED;
                    len_next  = cut ? '0 : inc[LEN_W-1:0];
                end
            end
            MODE_DISCARD:
            begin
                if (is_zero)
                begin
                    mode_next = MODE_SKIP;
                    len_next  = '0;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_SKIP;
                end
            end
            default:
            begin
                mode_next = MODE_SKIP;
                len_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        push_grp.res   = '0;
        push_grp.count = '0;
        if (slash_pre)
        begin
            push_grp.res[push_grp.count[RES_IDX_W-1:0]] = make_res(KIND_CHAR, CH_SLASH, 1'b0);
            push_grp.count = push_grp.count + RES_CNT_W'(1);
            if (lim_one)
            begin
                push_grp.res[push_grp.count[RES_IDX_W-1:0]] = make_res(KIND_END, CH_NUL, 1'b0);
                push_grp.count = push_grp.count + RES_CNT_W'(1);
            end
        end
        case (m_eff)
            MODE_SKIP:
            begin
                if (is_zero)
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                        make_res(KIND_EOT, CH_NUL, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                end
                else if (!is_ws && (c != CH_SLASH) && (c != CH_QUOTE))
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] = make_res(KIND_CHAR, c, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                    if (is_single || cut)
                    begin
                        push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                            make_res(KIND_END, CH_NUL, 1'b0);
                        push_grp.count = push_grp.count + RES_CNT_W'(1);
                    end
                end
            end
            MODE_WORD:
            begin
                if (is_zero || is_ws || is_single)
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                        make_res(KIND_END, CH_NUL, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                end
                if (is_zero)
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                        make_res(KIND_EOT, CH_NUL, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                end
                else if (!is_ws)
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] = make_res(KIND_CHAR, c, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                    if (is_single || cut)
                    begin
                        push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                            make_res(KIND_END, CH_NUL, 1'b0);
                        push_grp.count = push_grp.count + RES_CNT_W'(1);
                    end
                end
            end
            MODE_QUOTED:
            begin
                if (is_zero || (c == CH_QUOTE))
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                        make_res(KIND_END, CH_NUL, 1'b1);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                    if (is_zero)
                    begin
                        push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                            make_res(KIND_EOT, CH_NUL, 1'b0);
                        push_grp.count = push_grp.count + RES_CNT_W'(1);
                    end
                end
                else
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] = make_res(KIND_CHAR, c, 1'b1);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                    if (cut)
                    begin
                        push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                            make_res(KIND_END, CH_NUL, 1'b1);
                        push_grp.count = push_grp.count + RES_CNT_W'(1);
                    end
                end
            end
            MODE_COMMENT, MODE_DISCARD:
            begin
                if (is_zero)
                begin
                    push_grp.res[push_grp.count[RES_IDX_W-1:0]] =
                        make_res(KIND_EOT, CH_NUL, 1'b0);
                    push_grp.count = push_grp.count + RES_CNT_W'(1);
                end
            end
            default:
            begin
                push_grp.count = push_grp.count;
            end
        endcase
    end

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (push_grp.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SKIP;
            len_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: hw/rtl/stok_queue.sv
module stok_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  stok_pkg::group_t    push_grp,
    input  logic                pop,
    output stok_pkg::group_t    head_grp,
    output stok_pkg::q_status_t q_stat
);
    import stok_pkg::*;

    group_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_grp     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/stok_back.sv
module stok_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  stok_pkg::group_t    head_grp,
    input  stok_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // token_char
    output logic [2:0]          m_tuser,   // kind[1:0], quoted[2]
    output logic                m_tlast    // last
);
    import stok_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic [2:0]           m_tuser_reg;
    logic                 m_tlast_reg;
    logic                 load;
    logic                 is_last;
    result_t              cur;

    assign cur     = head_grp.res[idx_reg];
    assign is_last = (RES_CNT_W'(idx_reg) + RES_CNT_W'(1)) == head_grp.count;
    assign load    = !q_stat.empty && (!m_tvalid_reg || m_tready);
    assign pop     = load && is_last;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= cur.ch;
            m_tuser_reg <= {cur.quoted, cur.kind};
            m_tlast_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= is_last ? '0 : idx_reg + RES_IDX_W'(1);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/script_tokenizer.sv
// Script tokenizer: turns a stream of text bytes into a stream of token words.
// Input channel s_*: one text byte per word; byte 0 ends the text.
// Output channel m_*: one result per word; tuser[1:0] is the kind (token
// character, end of token, end of text), tuser[2] marks a quoted token,
// tdata carries the character, tlast marks the final result of one byte.
// Configuration: cfg_wr_en writes cfg_wr_data into the token length limit.
// Throughput: one text byte per cycle while the four-entry result queue has
// room; the output side drains one result per cycle while the receiver is
// ready, so a run of bytes that each cause more than one result is set by
// the output serialiser, not by the scanner.
// Path: a byte's results are registered into the queue and then, one at a
// time, into the output register.
// Reset: scanner skips whitespace, token length clears, limit returns to
// 8191, queue and output register empty.
// Stall: a stalled receiver holds the output word; the queue fills and then
// s_tready drops until space returns.
module script_tokenizer
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,     // text_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,     // token_char
    output logic [2:0]                 m_tuser,     // kind[1:0], quoted[2]
    output logic                       m_tlast,     // last
    input  logic                       cfg_wr_en,
    input  logic [stok_pkg::CFG_W-1:0] cfg_wr_data  // token_limit
);
    import stok_pkg::*;

    logic      push;
    logic      pop;
    group_t    push_grp;
    group_t    head_grp;
    q_status_t q_stat;

    stok_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_grp    (push_grp)
    );

    stok_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head_grp (head_grp),
        .q_stat   (q_stat)
    );

    stok_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_grp (head_grp),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/stok_checker.sv
module stok_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,
    input  logic [2:0]                 m_tuser,
    input  logic                       m_tlast,
    input  logic                       cfg_wr_en,
    input  logic [stok_pkg::CFG_W-1:0] cfg_wr_data
);
    import stok_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output word changed while stalled");

    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_EOT) |-> m_tlast && !m_tuser[2])
    else $error("end of text not final or marked quoted");

    a_nonchar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != KIND_CHAR) |-> (m_tdata == 8'h00))
    else $error("character data on a non-character word");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind script_tokenizer stok_checker u_stok_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);
